[hdl/isbp_pkg.sv]
package isbp_pkg;

  // Blob layout
  localparam int HEADER_BYTES = 8;
  localparam int WORD_BYTES   = 4;

  // Saturating byte counter
  localparam int CNT_W = 36;
  localparam logic [CNT_W-1:0] COUNTER_MAX = '1;

  // Supported record widths in bytes
  localparam logic [31:0] RW_2 = 32'd2;
  localparam logic [31:0] RW_4 = 32'd4;
  localparam logic [31:0] RW_8 = 32'd8;

  // Final-byte status codes
  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_SHORT_HDR     = 2'd1,
    ST_ZERO_WIDTH    = 2'd2,
    ST_SIZE_MISMATCH = 2'd3
  } status_t;

  // One parsed byte that produces a result, handed to the size check
  typedef struct packed {
    logic             have_entry;
    logic [63:0]      value;
    logic             last;
    logic [CNT_W-1:0] taken;
    logic             saturated;
    logic [31:0]      width;
    logic [31:0]      count;
  } isbp_item_t;

endpackage

[hdl/isbp_size_check.sv]
module isbp_size_check
  import isbp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  isbp_item_t         item,
  output logic               item_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               entry_valid,
  output logic signed [63:0] entry_value,
  output logic               blob_done,
  output logic [1:0]         parse_status
);

  // Product stage
  logic             s2_valid;
  logic             s2_have_entry;
  logic [63:0]      s2_value;
  logic             s2_last;
  logic [CNT_W-1:0] s2_taken;
  logic             s2_saturated;
  logic             s2_width_zero;
  logic [63:0]      s2_prod;

  logic        out_ready;
  logic        s2_ready;
  logic [63:0] prod_next;
  logic [CNT_W:0] expect_size;
  status_t     status_next;

  // Pipeline flow control
  assign out_ready  = !out_valid || !out_stall;
  assign s2_ready   = !s2_valid || out_ready;
  assign item_ready = s2_ready;

  // Payload size in bytes: count times width, full 64-bit product
  assign prod_next = 64'(item.width) * 64'(item.count);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= item_valid;
    end
    if (s2_ready) begin
      s2_have_entry <= item.have_entry;
      s2_value      <= item.value;
      s2_last       <= item.last;
      s2_taken      <= item.taken;
      s2_saturated  <= item.saturated;
      s2_width_zero <= (item.width == 32'd0);
      s2_prod       <= prod_next;
    end
  end

  // Checks on the final byte, in priority order
  assign expect_size = (CNT_W+1)'(s2_prod[CNT_W-1:0]) + (CNT_W+1)'(HEADER_BYTES);

  always_comb begin
    status_next = ST_OK;
    if (s2_last) begin
      if (s2_taken < CNT_W'(HEADER_BYTES)) begin
        status_next = ST_SHORT_HDR;
      end else if (s2_width_zero) begin
        status_next = ST_ZERO_WIDTH;
      end else if (s2_saturated || (s2_taken == COUNTER_MAX) ||
                   (s2_prod[63:CNT_W] != '0) ||
                   (expect_size != {1'b0, s2_taken})) begin
        status_next = ST_SIZE_MISMATCH;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s2_valid;
    end
    if (out_ready) begin
      entry_valid  <= s2_have_entry;
      entry_value  <= s2_value;
      blob_done    <= s2_last;
      parse_status <= status_next;
    end
  end

endmodule

[hdl/intset_blob_parser.sv]
// Integer-set blob parser.
// Input channel (in_valid / in_stall): one blob byte per transfer, data_byte,
// with last_byte high on the final byte. The blob is a little-endian 32-bit
// record width, a 32-bit entry count, then entries of 2, 4 or 8 bytes.
// Output channel (out_valid / out_stall): one transfer for each byte that
// completes an entry, ends the blob, or both. entry_value is the entry
// sign-extended to 64 bits; on the final byte blob_done is set and
// parse_status reports ok, short header, zero width or size mismatch. The
// consumer drops the blob's entries when the status is not ok.
// Throughput: one byte per cycle while in_stall is low. Each result passes
// through the parse register, the size product register and the result
// register. When out_stall is held the three stages fill and then in_stall
// rises; bytes that produce no result still need room in the first stage.
// Reset (rst, synchronous) empties the pipeline and clears the byte counter,
// header words and partial entry. After the final byte the same state is
// cleared so the next byte starts a new blob.
module intset_blob_parser
  import isbp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               entry_valid,
  output logic signed [63:0] entry_value,
  output logic               blob_done,
  output logic [1:0]         parse_status
);

  // Parse state
  logic [CNT_W-1:0] byte_counter, byte_counter_next;
  logic [31:0]      record_width, record_width_next;
  logic [31:0]      entry_count, entry_count_next;
  logic [63:0]      entry_accum, entry_accum_next;
  logic [3:0]       byte_in_entry, byte_in_entry_next;

  // Stage 1 register
  logic       s1_valid;
  isbp_item_t s1_item;

  logic       s1_ready;
  logic       s2_ready;
  logic       accept;
  isbp_item_t item_next;
  logic       have_entry;
  logic [63:0] accum_upd;
  logic [3:0]  bie_inc;
  logic [63:0] value_sx;
  logic        saturated;
  logic [CNT_W-1:0] taken;
  logic [31:0] width_upd;
  logic [31:0] count_upd;

  assign s1_ready = !s1_valid || s2_ready;
  assign in_stall = !s1_ready;
  assign accept   = in_valid && s1_ready;

  // Per-byte parse
  always_comb begin
    width_upd  = record_width;
    count_upd  = entry_count;
    accum_upd  = entry_accum | (64'(data_byte) << {byte_in_entry[2:0], 3'b000});
    bie_inc    = byte_in_entry + 4'd1;
    have_entry = 1'b0;
    entry_accum_next   = entry_accum;
    byte_in_entry_next = byte_in_entry;

    // Sign extension from the record width
    case (record_width)
      RW_2:    value_sx = {{48{accum_upd[15]}}, accum_upd[15:0]};
      RW_4:    value_sx = {{32{accum_upd[31]}}, accum_upd[31:0]};
      default: value_sx = accum_upd;
    endcase

    if (byte_counter[CNT_W-1:2] == '0) begin
      width_upd = record_width | (32'(data_byte) << {byte_counter[1:0], 3'b000});
    end else if (byte_counter[CNT_W-1:3] == '0) begin
      count_upd = entry_count | (32'(data_byte) << {byte_counter[1:0], 3'b000});
    end else if ((record_width == RW_2) || (record_width == RW_4) ||
                 (record_width == RW_8)) begin
      if (32'(bie_inc) >= record_width) begin
        have_entry         = 1'b1;
        entry_accum_next   = '0;
        byte_in_entry_next = '0;
      end else begin
        entry_accum_next   = accum_upd;
        byte_in_entry_next = bie_inc;
      end
    end

    // Saturating byte count
    saturated = (byte_counter == COUNTER_MAX);
    taken     = saturated ? COUNTER_MAX : byte_counter + CNT_W'(1);

    byte_counter_next = taken;
    record_width_next = width_upd;
    entry_count_next  = count_upd;
    if (last_byte) begin
      byte_counter_next  = '0;
      record_width_next  = '0;
      entry_count_next   = '0;
      entry_accum_next   = '0;
      byte_in_entry_next = '0;
    end

    item_next.have_entry = have_entry;
    item_next.value      = have_entry ? value_sx : 64'd0;
    item_next.last       = last_byte;
    item_next.taken      = taken;
    item_next.saturated  = saturated;
    item_next.width      = width_upd;
    item_next.count      = count_upd;
  end

  // State and stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_counter  <= '0;
      record_width  <= '0;
      entry_count   <= '0;
      entry_accum   <= '0;
      byte_in_entry <= '0;
      s1_valid      <= 1'b0;
    end else begin
      if (accept) begin
        byte_counter  <= byte_counter_next;
        record_width  <= record_width_next;
        entry_count   <= entry_count_next;
        entry_accum   <= entry_accum_next;
        byte_in_entry <= byte_in_entry_next;
      end
      if (s1_ready) begin
        s1_valid <= accept && (have_entry || last_byte);
      end
    end
    if (s1_ready) begin
      s1_item <= item_next;
    end
  end

  // Size product and status checks
  isbp_size_check u_size_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (s1_valid),
    .item         (s1_item),
    .item_ready   (s2_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .entry_valid  (entry_valid),
    .entry_value  (entry_value),
    .blob_done    (blob_done),
    .parse_status (parse_status)
  );

endmodule

[hdl/isbp_checker.sv]
module isbp_checker
  import isbp_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               entry_valid,
  input logic signed [63:0] entry_value,
  input logic               blob_done,
  input logic [1:0]         parse_status
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(entry_valid) &&
      $stable(entry_value) && $stable(blob_done) && $stable(parse_status)))
    else $error("stalled result changed");

  // Input is held off only while a result is stuck at the output
  a_in_stall_full: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |-> (out_valid && out_stall))
    else $error("input stalled with output free");

  // Every result carries an entry or ends a blob
  a_out_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entry_valid || blob_done))
    else $error("empty result transfer");

  // Status only on the final byte
  a_status_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !blob_done) |-> (parse_status == ST_OK))
    else $error("status set before end of blob");

  // No entry value without an entry
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !entry_valid) |-> (entry_value == 64'sd0))
    else $error("entry value without entry");

endmodule

bind intset_blob_parser isbp_checker u_isbp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .entry_valid  (entry_valid),
  .entry_value  (entry_value),
  .blob_done    (blob_done),
  .parse_status (parse_status)
);

[dv/intset_blob_parser_check.sv]
`timescale 1ns / 1ps

// Watches both channels of the blob parser, predicts each result from the
// accepted bytes and compares every output transfer against the oldest
// prediction.
module intset_blob_parser_check
  import isbp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               entry_valid,
  input  logic signed [63:0] entry_value,
  input  logic               blob_done,
  input  logic [1:0]         parse_status,
  output int                 fail_count,
  output int                 pending,
  output int                 results_checked,
  output int                 entries_checked
);

  typedef struct packed {
    logic        has_entry;
    logic [63:0] value;
    logic        done;
    status_t     status;
  } blob_result_t;

  blob_result_t expected_results[$];
  blob_result_t want;
  int           errs;
  int           n_results;
  int           n_entries_seen;

  // Parser state mirror
  logic [CNT_W-1:0] bytes_taken;
  logic [31:0]      rec_width;
  logic [31:0]      rec_count;
  logic [63:0]      partial_entry;
  logic [3:0]       bytes_held;

  function automatic void clear_blob();
    bytes_taken   = '0;
    rec_width     = '0;
    rec_count     = '0;
    partial_entry = '0;
    bytes_held    = '0;
  endfunction

  // Advance the mirror by one byte; queue the result it causes, if any
  function automatic void parse_byte(input logic [7:0] b, input logic fin);
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] taken;
    logic             sat;
    logic             got;
    logic [63:0]      val;
    logic [64:0]      want_size;
    status_t          st;
    blob_result_t     r;
    pos = bytes_taken;
    got = 1'b0;
    val = '0;
    st  = ST_OK;
    if (pos < WORD_BYTES) begin
      rec_width[8*pos[1:0] +: 8] = b;
    end else if (pos < HEADER_BYTES) begin
      rec_count[8*pos[1:0] +: 8] = b;
    end else if (rec_width == RW_2 || rec_width == RW_4 || rec_width == RW_8) begin
      partial_entry[8*bytes_held[2:0] +: 8] = b;
      bytes_held = bytes_held + 4'd1;
      if (bytes_held >= rec_width) begin
        got = 1'b1;
        // sign-extend from the record width
        case (rec_width)
          RW_2:    val = {{48{partial_entry[15]}}, partial_entry[15:0]};
          RW_4:    val = {{32{partial_entry[31]}}, partial_entry[31:0]};
          default: val = partial_entry;
        endcase
        partial_entry = '0;
        bytes_held    = '0;
      end
    end

    sat         = (pos >= COUNTER_MAX);
    taken       = sat ? COUNTER_MAX : pos + 1'b1;
    bytes_taken = taken;

    // Size checks on the final byte, in priority order
    if (fin) begin
      if (taken < HEADER_BYTES) begin
        st = ST_SHORT_HDR;
      end else if (rec_width == '0) begin
        st = ST_ZERO_WIDTH;
      end else begin
        want_size = 65'(HEADER_BYTES) + 65'(rec_count) * 65'(rec_width);
        if (sat || taken >= COUNTER_MAX || want_size != 65'(taken)) begin
          st = ST_SIZE_MISMATCH;
        end
      end
    end

    if (got || fin) begin
      r.has_entry = got;
      r.value     = val;
      r.done      = fin;
      r.status    = st;
      expected_results.push_back(r);
    end
    if (fin) begin
      clear_blob();
    end
  endfunction

  // Output check first, so a result can never match a byte taken this edge
  always @(posedge clk) begin
    if (rst) begin
      clear_blob();
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (entry_valid) begin
          n_entries_seen++;
        end
        if (expected_results.size() == 0) begin
          $error("result transfer with no expectation pending");
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (entry_valid !== want.has_entry) begin
            $error("entry_valid expected %0b got %0b", want.has_entry, entry_valid);
            errs++;
          end
          if (entry_value !== want.value) begin
            $error("entry_value expected %0d got %0d", $signed(want.value), entry_value);
            errs++;
          end
          if (blob_done !== want.done) begin
            $error("blob_done expected %0b got %0b", want.done, blob_done);
            errs++;
          end
          if (parse_status !== want.status) begin
            $error("parse_status expected %0d got %0d", want.status, parse_status);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        parse_byte(data_byte, last_byte);
      end
    end
    fail_count      <= errs;
    pending         <= expected_results.size();
    results_checked <= n_results;
    entries_checked <= n_entries_seen;
  end

  initial begin
    errs           = 0;
    n_results      = 0;
    n_entries_seen = 0;
    clear_blob();
  end

endmodule

[dv/intset_blob_parser_tb.sv]
`timescale 1ns / 1ps

module intset_blob_parser_tb
  import isbp_pkg::*;
;

  localparam int TARGET_BYTES     = 750;
  localparam int QUIET_AFTER      = 650;
  localparam int LONG_HOLD_START  = 300;
  localparam int LONG_HOLD_CYCLES = 60;

  typedef enum int {
    BK_GOOD,
    BK_MISMATCH,
    BK_SHORT,
    BK_ZERO_W,
    BK_ODD_W,
    BK_RAW_HDR,
    BK_NUM
  } blob_kind_t;

  logic               clk;
  logic               rst          = 1'b1;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic [7:0]         data_byte    = '0;
  logic               last_byte    = 1'b0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic               entry_valid;
  logic signed [63:0] entry_value;
  logic               blob_done;
  logic [1:0]         parse_status;

  int fail_count;
  int pending;
  int results_checked;
  int entries_checked;

  logic [7:0] blob_bytes[$];
  int         bytes_sent  = 0;
  int         blobs_sent  = 0;
  int         kind_count[BK_NUM];
  logic       quiet       = 1'b0;

  intset_blob_parser uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .entry_valid  (entry_valid),
    .entry_value  (entry_value),
    .blob_done    (blob_done),
    .parse_status (parse_status)
  );

  intset_blob_parser_check u_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .last_byte       (last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .entry_valid     (entry_valid),
    .entry_value     (entry_value),
    .blob_done       (blob_done),
    .parse_status    (parse_status),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .entries_checked (entries_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

  // Little-endian bytes of v, n of them
  task automatic add_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) begin
      blob_bytes.push_back(v[8*i +: 8]);
    end
  endtask

  // Entry value: extremes for width w now and then, random otherwise
  function automatic logic [63:0] pick_entry(input int w);
    logic [63:0] msb;
    msb = 64'd1 << (8*w - 1);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return msb;
      3:       return msb - 64'd1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Payload of whole entries, cut off after nbytes
  task automatic add_entries(input int w, input int nbytes);
    logic [63:0] v;
    int          stop;
    stop = blob_bytes.size() + nbytes;
    while (blob_bytes.size() < stop) begin
      v = pick_entry(w);
      for (int i = 0; i < w && blob_bytes.size() < stop; i++) begin
        blob_bytes.push_back(v[8*i +: 8]);
      end
    end
  endtask

  task automatic add_noise(input int n);
    for (int i = 0; i < n; i++) begin
      blob_bytes.push_back(8'($urandom));
    end
  endtask

  // One byte transfer, with an occasional gap ahead of it
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (bytes_sent >= QUIET_AFTER) begin
      quiet = 1'b1;
    end
  endtask

  task automatic ship_blob(input blob_kind_t kind);
    for (int i = 0; i < blob_bytes.size(); i++) begin
      send_byte(blob_bytes[i], i == blob_bytes.size() - 1);
    end
    blob_bytes.delete();
    blobs_sent++;
    kind_count[kind]++;
  endtask

  function automatic logic [31:0] good_width();
    case ($urandom_range(0, 2))
      0:       return RW_2;
      1:       return RW_4;
      default: return RW_8;
    endcase
  endfunction

  task automatic make_blob(input blob_kind_t kind);
    int w;
    int c;
    int n;
    case (kind)
      BK_GOOD: begin
        w = good_width();
        c = $urandom_range(0, 6);
        add_le(w, 4);
        add_le(c, 4);
        add_entries(w, c * w);
      end
      // wrong payload length: extra entries, missing entries or a cut entry
      BK_MISMATCH: begin
        w = good_width();
        c = $urandom_range(0, 6);
        do n = $urandom_range(0, c * w + 3 * w); while (n == c * w);
        add_le(w, 4);
        add_le(c, 4);
        add_entries(w, n);
      end
      BK_SHORT: begin
        add_noise($urandom_range(1, HEADER_BYTES - 1));
      end
      BK_ZERO_W: begin
        add_le(0, 4);
        add_le($urandom_range(0, 1) ? $urandom : $urandom_range(0, 3), 4);
        add_noise($urandom_range(0, 6));
      end
      // unsupported width: bytes only count toward the size
      BK_ODD_W: begin
        do w = $urandom_range(1, 16); while (w == 2 || w == 4 || w == 8);
        c = $urandom_range(0, 3);
        n = c * w + ($urandom_range(0, 3) == 0);
        add_le(w, 4);
        add_le(c, 4);
        add_noise(n);
      end
      default: begin
        add_le($urandom, 4);
        add_le($urandom, 4);
        add_noise($urandom_range(0, 6));
      end
    endcase
  endtask

  // Receiver: short random stalls, one long hold-off, none at the end
  initial begin
    int cyc;
    int hold_left;
    cyc       = 0;
    hold_left = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == LONG_HOLD_START) begin
        hold_left = LONG_HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int         waited;
    blob_kind_t kind;
    int         r;
    foreach (kind_count[k]) kind_count[k] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // width 2 with sign boundary entries
    add_le(RW_2, 4);
    add_le(3, 4);
    add_le(16'h8000, 2);
    add_le(16'h7FFF, 2);
    add_le(16'hFFFF, 2);
    ship_blob(BK_GOOD);
    // single-byte blob: short header
    blob_bytes.push_back(8'hFF);
    ship_blob(BK_SHORT);
    // header only, zero width
    add_le(0, 8);
    ship_blob(BK_ZERO_W);

    // random blobs, first one of each kind, then mostly well-formed
    while (bytes_sent < TARGET_BYTES) begin
      if (blobs_sent - 3 < BK_NUM) begin
        kind = blob_kind_t'(blobs_sent - 3);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55)      kind = BK_GOOD;
        else if (r < 67) kind = BK_MISMATCH;
        else if (r < 75) kind = BK_SHORT;
        else if (r < 83) kind = BK_ZERO_W;
        else if (r < 92) kind = BK_ODD_W;
        else             kind = BK_RAW_HDR;
      end
      make_blob(kind);
      ship_blob(kind);
    end
    in_valid <= 1'b0;

    // drain
    waited = 0;
    while (pending != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pending != 0) begin
      $error("%0d expected results never arrived", pending);
    end

    $display("Sent %0d bytes in %0d blobs: %0d good, %0d wrong size, %0d short header,",
             bytes_sent, blobs_sent, kind_count[BK_GOOD], kind_count[BK_MISMATCH],
             kind_count[BK_SHORT]);
    $display("  %0d zero width, %0d odd width, %0d random header; %0d results, %0d entries",
             kind_count[BK_ZERO_W], kind_count[BK_ODD_W], kind_count[BK_RAW_HDR],
             results_checked, entries_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/isbp_pkg.sv
hdl/isbp_size_check.sv
hdl/intset_blob_parser.sv
hdl/isbp_checker.sv
dv/intset_blob_parser_check.sv
dv/intset_blob_parser_tb.sv
